// ----- src/length_prefixed_to_start_code_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef LENGTH_PREFIXED_TO_START_CODE_ASSERT_SVH
`define LENGTH_PREFIXED_TO_START_CODE_ASSERT_SVH

// same-cycle implication
`define LPSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define LPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/lpsc_pkg.sv -----
`default_nettype none
package lpsc_pkg;

	localparam int BLOCK_LEN_BITS_DEF = 24;
	localparam int LEN_FIELD_W = 3;
	localparam logic [LEN_FIELD_W-1:0] LEN_FIELD_RESET = 3'd4;
	localparam logic [LEN_FIELD_W-1:0] LEN_FIELD_MIN = 3'd1;
	localparam logic [LEN_FIELD_W-1:0] LEN_FIELD_MAX = 3'd4;
	localparam int ACC_W = 32;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] START_ZERO = 8'h00;
	localparam logic [7:0] START_ONE = 8'h01;
	localparam logic [1:0] START_LAST_BEAT = 2'd3;

	typedef enum logic [1:0] {
		CMD_START,
		CMD_PAYLOAD,
		CMD_ERROR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] data;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// ----- src/lpsc_in_if.sv -----
`default_nettype none
interface lpsc_in_if #(
	parameter int BLOCK_LEN_BITS = lpsc_pkg::BLOCK_LEN_BITS_DEF
);
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic block_first;
	logic [BLOCK_LEN_BITS-1:0] block_length;
	logic block_corrupt;

	modport source (output valid, data_byte, block_first, block_length, block_corrupt,
		input ready);
	modport sink (input valid, data_byte, block_first, block_length, block_corrupt,
		output ready);
endinterface
`default_nettype wire

// ----- src/lpsc_out_if.sv -----
`default_nettype none
interface lpsc_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic unit_first;
	logic unit_last;
	logic size_error;
	logic run_last;

	modport source (output valid, out_byte, unit_first, unit_last, size_error, run_last,
		input ready);
	modport sink (input valid, out_byte, unit_first, unit_last, size_error, run_last,
		output ready);
endinterface
`default_nettype wire

// ----- src/lpsc_cfg_if.sv -----
`default_nettype none
interface lpsc_cfg_if;
	logic valid;
	logic ready;
	logic [lpsc_pkg::LEN_FIELD_W-1:0] length_field_bytes;

	modport source (output valid, length_field_bytes, input ready);
	modport sink (input valid, length_field_bytes, output ready);
endinterface
`default_nettype wire

// ----- src/lpsc_front.sv -----
`default_nettype none
module lpsc_front #(
	parameter int BLOCK_LEN_BITS = lpsc_pkg::BLOCK_LEN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	lpsc_in_if.sink           din,
	lpsc_cfg_if.sink          cfg,
	input  lpsc_pkg::q_stat_t q_stat,
	output logic              push,
	output lpsc_pkg::cmd_t    push_cmd
);
	import lpsc_pkg::*;

	typedef enum logic [1:0] {
		PH_DISCARD,
		PH_LENGTH,
		PH_PAYLOAD
	} phase_t;

	phase_t phase_q, phase_d;
	logic [LEN_FIELD_W-1:0] lfb_q;
	logic [LEN_FIELD_W-1:0] seen_q, seen_d, seen_inc, n_eff;
	logic [ACC_W-1:0] acc_q, acc_d, acc_sh;
	logic [BLOCK_LEN_BITS-1:0] bl_q, bl_d, bl_dec;
	logic [BLOCK_LEN_BITS-1:0] pl_q, pl_d, pl_dec;
	logic push_d;
	logic accept;

	assign din.ready = !q_stat.full;
	assign cfg.ready = 1'b1;
	assign accept = din.valid && din.ready;

	always_comb begin
		if (lfb_q < LEN_FIELD_MIN) begin
			n_eff = LEN_FIELD_MIN;
		end else if (lfb_q > LEN_FIELD_MAX) begin
			n_eff = LEN_FIELD_MAX;
		end else begin
			n_eff = lfb_q;
		end

		phase_d = phase_q;
		seen_d = seen_q;
		acc_d = acc_q;
		bl_d = bl_q;
		pl_d = pl_q;
		if (din.block_first) begin
			phase_d = din.block_corrupt ? PH_DISCARD : PH_LENGTH;
			seen_d = '0;
			acc_d = '0;
			bl_d = din.block_length;
			pl_d = '0;
		end

		acc_sh = {acc_d[ACC_W-9:0], din.data_byte};
		seen_inc = seen_d + 1'b1;
		bl_dec = bl_d - 1'b1;
		pl_dec = pl_d - 1'b1;

		push_d = 1'b0;
		push_cmd.kind = CMD_PAYLOAD;
		push_cmd.data = din.data_byte;
		push_cmd.last = 1'b0;

		case (phase_d)
			PH_LENGTH: begin
				if (seen_d == '0 && bl_d < BLOCK_LEN_BITS'(n_eff)) begin
					// short tail: drop silently
					phase_d = PH_DISCARD;
				end else begin
					acc_d = acc_sh;
					seen_d = seen_inc;
					bl_d = bl_dec;
					if (seen_inc >= n_eff) begin
						seen_d = '0;
						acc_d = '0;
						push_d = 1'b1;
						// bl_dec is the byte count left after this one
						if (acc_sh == '0 || acc_sh > ACC_W'(bl_dec)) begin
							phase_d = PH_DISCARD;
							push_cmd.kind = CMD_ERROR;
						end else begin
							phase_d = PH_PAYLOAD;
							pl_d = BLOCK_LEN_BITS'(acc_sh);
							push_cmd.kind = CMD_START;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				if (pl_d == '0 || bl_d == '0) begin
					phase_d = PH_DISCARD;
				end else begin
					bl_d = bl_dec;
					pl_d = pl_dec;
					push_d = 1'b1;
					push_cmd.last = (pl_dec == '0);
					if (pl_dec == '0) begin
						phase_d = PH_LENGTH;
					end
				end
			end
			default: ;
		endcase
	end

	assign push = accept && push_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfb_q <= LEN_FIELD_RESET;
			phase_q <= PH_DISCARD;
			seen_q <= '0;
			acc_q <= '0;
			bl_q <= '0;
			pl_q <= '0;
		end else begin
			if (cfg.valid) begin
				lfb_q <= cfg.length_field_bytes;
			end
			if (accept) begin
				phase_q <= phase_d;
				seen_q <= seen_d;
				acc_q <= acc_d;
				bl_q <= bl_d;
				pl_q <= pl_d;
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/lpsc_queue.sv -----
`default_nettype none
module lpsc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lpsc_pkg::cmd_t     push_cmd,
	input  logic               pop,
	output lpsc_pkg::cmd_t     head,
	output lpsc_pkg::q_stat_t  q_stat
);
	import lpsc_pkg::*;

	cmd_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0] cnt_q;

	assign head = mem_q[rd_ptr_q];
	assign q_stat.full = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/lpsc_back.sv -----
`default_nettype none
module lpsc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lpsc_pkg::q_stat_t q_stat,
	input  lpsc_pkg::cmd_t    head,
	output logic              pop,
	lpsc_out_if.source        dout
);
	import lpsc_pkg::*;

	logic [1:0] beat_q;
	logic valid_q;
	logic [7:0] byte_q;
	logic first_q, last_q, err_q, runl_q;
	logic load;
	logic [7:0] byte_d;
	logic first_d, last_d, err_d, runl_d;

	// output register takes a new word when empty or being drained
	assign load = !q_stat.empty && (!valid_q || dout.ready);
	assign pop = load && (head.kind != CMD_START || beat_q == START_LAST_BEAT);

	always_comb begin
		byte_d = head.data;
		first_d = 1'b0;
		last_d = 1'b0;
		err_d = 1'b0;
		runl_d = 1'b1;
		case (head.kind)
			CMD_START: begin
				byte_d = (beat_q == START_LAST_BEAT) ? START_ONE : START_ZERO;
				first_d = (beat_q == '0);
				runl_d = (beat_q == START_LAST_BEAT);
			end
			CMD_PAYLOAD: begin
				last_d = head.last;
			end
			CMD_ERROR: begin
				byte_d = START_ZERO;
				err_d = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				beat_q <= pop ? '0 : beat_q + 1'b1;
			end else if (dout.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_d;
			first_q <= first_d;
			last_q <= last_d;
			err_q <= err_d;
			runl_q <= runl_d;
		end
	end

	assign dout.valid = valid_q;
	assign dout.out_byte = byte_q;
	assign dout.unit_first = first_q;
	assign dout.unit_last = last_q;
	assign dout.size_error = err_q;
	assign dout.run_last = runl_q;

endmodule
`default_nettype wire

// ----- src/length_prefixed_to_start_code.sv -----
// Length-prefixed access block to start-code stream converter.
// din: one word per byte of an access block; block_first marks the first
// byte and carries block_length and block_corrupt with it.
// cfg: write-only length_field_bytes (clamped to 1..4, reset 4); always ready.
// Write only while the block is idle.
// dout: start code 00 00 00 01 ahead of each unit's payload, unit_first on
// the first start-code byte, unit_last on the final payload byte, or one
// word with size_error set for a bad unit length. run_last closes the words
// caused by one input byte.
// Throughput: one input word per cycle while the command queue has room; a
// unit start yields four output words, so the output side paces the stream
// at those points. Path: the classifier pushes into a 4-deep command queue,
// which feeds the output register.
// Reset clears the classifier to drop bytes until the next block_first and
// empties the queue. A stalled receiver holds the output register; the
// queue fills and din.ready drops when it is full.
`default_nettype none
`include "length_prefixed_to_start_code_assert.svh"
module length_prefixed_to_start_code #(
	parameter int BLOCK_LEN_BITS = lpsc_pkg::BLOCK_LEN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lpsc_in_if.sink     din,
	lpsc_cfg_if.sink    cfg,
	lpsc_out_if.source  dout
);
	import lpsc_pkg::*;

	q_stat_t q_stat;
	cmd_t push_cmd, head;
	logic push, pop;

	lpsc_front #(
		.BLOCK_LEN_BITS(BLOCK_LEN_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din),
		.cfg      (cfg),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lpsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	lpsc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.head   (head),
		.pop    (pop),
		.dout   (dout)
	);

	`LPSC_ASSERT_IMPL(a_err_alone, clk, arst_n, dout.valid && dout.size_error, dout.run_last && !dout.unit_first && !dout.unit_last)
	`LPSC_ASSERT_IMPL(a_first_zero, clk, arst_n, dout.valid && dout.unit_first, dout.out_byte == START_ZERO && !dout.run_last)
	`LPSC_ASSERT_NEXT(a_start_cont, clk, arst_n, dout.valid && dout.ready && dout.unit_first, dout.valid && !dout.unit_first && dout.out_byte == START_ZERO)
	`LPSC_ASSERT_IMPL(a_q_sane, clk, arst_n, q_stat.full, !q_stat.empty && !din.ready)

endmodule
`default_nettype wire
